// ----- design/gppd_pkg.sv -----
// gppd_pkg: shared constants for the gated pulse presence detector
// holds field widths, reset values and configuration register indexes
// no dependencies
package gppd_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int MASK_W       = 16;
  localparam int SEL_W        = 4;
  localparam int COUNT_W      = 16;
  localparam int WINDOW_W     = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [COUNT_W-1:0]  COUNT_MAX          = 16'd65534;
  localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST   = 8'd40;
  localparam logic [COUNT_W-1:0]  THRESHOLD_RST      = 16'd6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_TICKS       = 1'b0,
    REG_PRESENCE_THRESHOLD = 1'b1
  } cfg_reg_t;

endpackage

// ----- design/gppd_if.sv -----
// gppd_req_if / gppd_rsp_if: valid-ready channels for requests and results
// depends on gppd_pkg for payload widths
interface gppd_req_if;
  import gppd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  edge_mask;
  logic               gate_tick;
  logic [SEL_W-1:0]   read_channel;

  modport source (output valid, edge_mask, gate_tick, read_channel, input ready);
  modport sink   (input valid, edge_mask, gate_tick, read_channel, output ready);
endinterface

interface gppd_rsp_if;
  import gppd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  status_mask;
  logic               window_closed;
  logic [COUNT_W-1:0] read_count;

  modport source (output valid, status_mask, window_closed, read_count, input ready);
  modport sink   (input valid, status_mask, window_closed, read_count, output ready);
endinterface

// ----- design/gated_pulse_presence_detector.sv -----
// gated_pulse_presence_detector: gated multichannel pulse counter, top level
// depends on gppd_pkg and the channel interfaces in gppd_if.sv
//
// usage:
//   req carries one request per cycle unless stalled: a mask of channels that
//   saw a falling edge, a gate tick flag and a channel to read back. rsp
//   returns exactly one result per request: the presence bits, whether the
//   request closed a window, and the latched count of the chosen channel.
//   cfg_we/cfg_index/cfg_data write window_ticks (index 0) and
//   presence_threshold (index 1); write only while no request is in flight.
//   result: registered; it appears in the cycle after its request is taken.
//   throughput: one request per cycle while not stalled; all channel
//   counters, the window counter and the threshold compares update in
//   parallel in that cycle, and the result register is the only stage.
//   stall: while a result waits in the result register and rsp.ready is low,
//   req.ready is low; a result taken in a cycle frees room for a new request
//   in the same cycle.
//   reset: rst (synchronous) clears all counts, the window counter, presence
//   bits and the result valid, and loads window_ticks 40 and threshold 6.
module gated_pulse_presence_detector #(
  parameter int CHANNELS = gppd_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  gppd_req_if.sink                            req,
  gppd_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [gppd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gppd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gppd_pkg::*;

  // only the channels that the edge mask can reach ever count
  localparam int LIVE_N = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  logic [WINDOW_W-1:0] window_ticks;
  logic [COUNT_W-1:0]  presence_threshold;

  logic [COUNT_W-1:0]  live_counts    [LIVE_N];
  logic [COUNT_W-1:0]  latched_counts [LIVE_N];
  logic [WINDOW_W-1:0] window_counter;
  logic [MASK_W-1:0]   presence_bits;

  logic [COUNT_W-1:0]  live_inc       [LIVE_N];
  logic [COUNT_W-1:0]  live_next      [LIVE_N];
  logic [COUNT_W-1:0]  latched_next   [LIVE_N];
  logic [WINDOW_W-1:0] window_counter_next;
  logic [MASK_W-1:0]   presence_next;
  logic [WINDOW_W:0]   tick_sum;
  logic                close;
  logic [COUNT_W-1:0]  read_next;

  logic                rsp_valid;
  logic                accept;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;

  // tick count formed one bit wider so window_ticks of 255 still closes
  assign tick_sum = {1'b0, window_counter} + {{WINDOW_W{1'b0}}, 1'b1};
  assign close    = req.gate_tick && (tick_sum > {1'b0, window_ticks});

  always_comb begin
    presence_next       = presence_bits;
    window_counter_next = window_counter;
    if (req.gate_tick) begin
      window_counter_next = close ? '0 : tick_sum[WINDOW_W-1:0];
    end
    if (close) begin
      presence_next = '0;
    end
    read_next = '0;
    for (int i = 0; i < LIVE_N; i++) begin
      // wrap from the top count straight to zero
      live_inc[i] = (live_counts[i] == COUNT_MAX) ? '0 : live_counts[i] + 1'b1;
      if (req.edge_mask[i]) begin
        live_next[i] = live_inc[i];
      end else begin
        live_next[i] = live_counts[i];
      end
      latched_next[i] = latched_counts[i];
      if (close) begin
        latched_next[i]  = live_next[i];
        presence_next[i] = (live_next[i] >= presence_threshold);
        live_next[i]     = '0;
      end
      if (req.read_channel == SEL_W'(i)) begin
        read_next = latched_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks       <= WINDOW_TICKS_RST;
      presence_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_TICKS:       window_ticks       <= cfg_data[WINDOW_W-1:0];
        REG_PRESENCE_THRESHOLD: presence_threshold <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_counter <= '0;
      presence_bits  <= '0;
      for (int i = 0; i < LIVE_N; i++) begin
        live_counts[i]    <= '0;
        latched_counts[i] <= '0;
      end
    end else if (accept) begin
      window_counter <= window_counter_next;
      presence_bits  <= presence_next;
      for (int i = 0; i < LIVE_N; i++) begin
        live_counts[i]    <= live_next[i];
        latched_counts[i] <= latched_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status_mask   <= presence_next;
      rsp.window_closed <= close;
      rsp.read_count    <= read_next;
    end
  end

endmodule

// ----- design/gppd_checker.sv -----
// gppd_checker: port-level checks for the gated pulse presence detector
// depends on gppd_pkg; bound to gated_pulse_presence_detector below
module gppd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [gppd_pkg::MASK_W-1:0]   rsp_status_mask,
  input logic                          rsp_window_closed,
  input logic [gppd_pkg::COUNT_W-1:0]  rsp_read_count
);
  import gppd_pkg::*;

  // every taken request produces a result in the next cycle
  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("request taken without a result the next cycle");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status_mask)
      && $stable(rsp_window_closed) && $stable(rsp_read_count))
    else $error("stalled result changed");

  // no new request while the result register is full and blocked
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request ready while result is stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind gated_pulse_presence_detector gppd_checker u_gppd_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status_mask   (rsp.status_mask),
  .rsp_window_closed (rsp.window_closed),
  .rsp_read_count    (rsp.read_count)
);

// ----- dv/gppd_presence_checker.sv -----
// gppd_presence_checker: watches the request, result and register ports of the
// gated pulse presence detector, predicts each result and compares it
// depends on gppd_pkg and the channel interfaces in gppd_if.sv
module gppd_presence_checker
  import gppd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  gppd_req_if                    req,
  gppd_rsp_if                    rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MASK_W-1:0]  status_mask;
    logic               window_closed;
    logic [COUNT_W-1:0] read_count;
  } detector_result_t;

  logic [COUNT_W-1:0]  live_count    [CHANNELS_DEF];
  logic [COUNT_W-1:0]  latched_count [CHANNELS_DEF];
  logic [WINDOW_W-1:0] tick_count;
  logic [WINDOW_W-1:0] window_len;
  logic [COUNT_W-1:0]  threshold;
  logic [MASK_W-1:0]   presence;

  detector_result_t predicted_results[$];
  int error_total = 0;
  int queued = 0;

  assign mismatches  = error_total;
  assign outstanding = queued;

  task automatic report_mismatch(input string msg);
    if (error_total < 100) $display("[%0t] mismatch: %s", $time, msg);
    error_total++;
  endtask

  // edges first, then the tick; a close relatches every channel at once
  function automatic detector_result_t count_and_gate(input logic [MASK_W-1:0] mask,
                                                      input logic tick,
                                                      input logic [SEL_W-1:0] sel);
    detector_result_t res;
    logic [WINDOW_W:0] advanced;
    res.window_closed = 1'b0;
    for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
      if (mask[ch]) live_count[ch] = (live_count[ch] == COUNT_MAX) ? '0 : live_count[ch] + 1'b1;
    end
    if (tick) begin
      advanced = {1'b0, tick_count} + 1'b1;
      if (advanced > {1'b0, window_len}) begin
        tick_count = '0;
        presence   = '0;
        for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
          latched_count[ch] = live_count[ch];
          live_count[ch]    = '0;
          if (latched_count[ch] >= threshold) presence[ch] = 1'b1;
        end
        res.window_closed = 1'b1;
      end else begin
        tick_count = advanced[WINDOW_W-1:0];
      end
    end
    res.status_mask = presence;
    res.read_count  = latched_count[sel];
    return res;
  endfunction

  always @(posedge clk) begin
    detector_result_t want;
    if (rst) begin
      for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
        live_count[ch]    = '0;
        latched_count[ch] = '0;
      end
      tick_count = '0;
      presence   = '0;
      window_len = WINDOW_TICKS_RST;
      threshold  = THRESHOLD_RST;
      predicted_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_TICKS:       window_len = cfg_data[WINDOW_W-1:0];
          REG_PRESENCE_THRESHOLD: threshold  = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // the result leaving belongs to an older request than the one entering
      if (rsp.valid && rsp.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (read_count 0x%0h)",
                                    rsp.read_count));
        end else begin
          want = predicted_results.pop_front();
          if (rsp.status_mask !== want.status_mask)
            report_mismatch($sformatf("status_mask got 0x%0h expected 0x%0h",
                                      rsp.status_mask, want.status_mask));
          if (rsp.window_closed !== want.window_closed)
            report_mismatch($sformatf("window_closed got %0b expected %0b",
                                      rsp.window_closed, want.window_closed));
          if (rsp.read_count !== want.read_count)
            report_mismatch($sformatf("read_count got 0x%0h expected 0x%0h",
                                      rsp.read_count, want.read_count));
        end
      end
      if (req.valid && req.ready)
        predicted_results.push_back(count_and_gate(req.edge_mask, req.gate_tick,
                                                   req.read_channel));
    end
    queued <= predicted_results.size();
  end

endmodule

// ----- dv/gated_pulse_presence_detector_tb.sv -----
// gated_pulse_presence_detector_tb: drives requests and register writes into the
// presence detector with random idling on both sides and gives the verdict
// depends on gppd_pkg, gppd_if.sv, the block and gppd_presence_checker
module gated_pulse_presence_detector_tb
  import gppd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SETS     = 8;
  localparam int ITEMS_PER_SET   = 200;
  localparam int SETTLE_CYCLES   = 4;
  localparam int LONG_HOLD       = 250;
  localparam int CYCLE_LIMIT     = 4000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    outstanding;
  int                    cycle_count = 0;
  bit                    quick = 1'b0;
  bit                    hold_kick = 1'b0;

  gppd_req_if req_ch ();
  gppd_rsp_if rsp_ch ();

  gated_pulse_presence_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gppd_presence_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one; quick mode keeps them tiny
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (quick) return (r < 70) ? 0 : $urandom_range(1, 2);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, free-running stretches, one long hold on demand
  initial begin
    int hold_left;
    int free_left;
    bit kick_seen;
    hold_left = 0;
    free_left = 0;
    kick_seen = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick != kick_seen) begin
        kick_seen = hold_kick;
        hold_left = LONG_HOLD;
        free_left = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (free_left > 0) begin
        rsp_ch.ready <= 1'b1;
        free_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        free_left = $urandom_range(20, 120);
        rsp_ch.ready <= 1'b1;
      end else begin
        hold_left = idle_span();
        if (hold_left > 0) begin
          rsp_ch.ready <= 1'b0;
          hold_left--;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // called just after a rising edge; returns just after the edge that took the request
  task automatic send_request(input logic [MASK_W-1:0] mask, input logic tick,
                             input logic [SEL_W-1:0] sel, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.edge_mask    <= mask;
    req_ch.gate_tick    <= tick;
    req_ch.read_channel <= sel;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned       win_set  [RANDOM_SETS] = '{1, 3, 10, 0, 7, 2, 5, 1};
    int unsigned       thr_set  [RANDOM_SETS] = '{0, 2, 5, 1, 8, 3, 12, 0};
    int unsigned       tick_pct [RANDOM_SETS] = '{50, 40, 60, 30, 50, 25, 70, 45};
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    logic [MASK_W-1:0] m;

    req_ch.valid        = 1'b0;
    req_ch.edge_mask    = '0;
    req_ch.gate_tick    = 1'b0;
    req_ch.read_channel = '0;
    cfg_we              = 1'b0;
    cfg_index           = REG_WINDOW_TICKS;
    cfg_data            = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under reset settings
    send_request(16'h0000, 1'b0, 4'd0, idle_span());
    send_request(16'hFFFF, 1'b0, 4'd15, idle_span());
    send_request(16'hAAAA, 1'b0, 4'd5, idle_span());
    send_request(16'h5555, 1'b0, 4'd10, idle_span());
    send_request(16'hFFFF, 1'b1, 4'd3, idle_span());
    // shortest nonzero window: every second tick closes
    wait_idle();
    set_register(REG_WINDOW_TICKS, 16'd1);
    send_request(16'h0F0F, 1'b1, 4'd8, idle_span());
    send_request(16'h0001, 1'b0, 4'd0, idle_span());
    // zero threshold sets every presence bit on close
    wait_idle();
    set_register(REG_PRESENCE_THRESHOLD, 16'd0);
    send_request(16'h0000, 1'b1, 4'd7, idle_span());
    send_request(16'h0000, 1'b1, 4'd7, idle_span());
    // zero window: every tick closes
    wait_idle();
    set_register(REG_WINDOW_TICKS, 16'd0);
    send_request(16'h8001, 1'b1, 4'd15, idle_span());
    send_request(16'h0000, 1'b1, 4'd0, idle_span());
    // window shortened below the running tick count
    wait_idle();
    set_register(REG_WINDOW_TICKS, 16'd40);
    set_register(REG_PRESENCE_THRESHOLD, 16'd2);
    repeat (5) send_request(16'h00F0, 1'b1, 4'd4, idle_span());
    wait_idle();
    set_register(REG_WINDOW_TICKS, 16'd2);
    send_request(16'h0000, 1'b1, 4'd4, idle_span());

    // random sets, each with its own window, threshold and tick rate
    for (int s = 0; s < RANDOM_SETS; s++) begin
      wait_idle();
      if (s == RANDOM_SETS - 1) begin
        win_set[s] = $urandom_range(1, 12);
        thr_set[s] = $urandom_range(0, 15);
      end
      set_register(REG_WINDOW_TICKS, CFG_DATA_W'(win_set[s]));
      set_register(REG_PRESENCE_THRESHOLD, CFG_DATA_W'(thr_set[s]));
      // result side holds off while requests keep coming
      if (s == 2) hold_kick = ~hold_kick;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        a = MASK_W'($urandom);
        b = MASK_W'($urandom);
        case ($urandom_range(0, 4))
          0:       m = a & b;
          1, 2:    m = a;
          3:       m = a | b;
          default: m = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        send_request(m, $urandom_range(0, 99) < tick_pct[s],
                     SEL_W'($urandom_range(0, 15)),
                     ((n / 40) % 3 == 2) ? 0 : idle_span());
      end
    end

    // widest window: 255 ticks stay open, the next one closes
    wait_idle();
    quick = 1'b1;
    set_register(REG_WINDOW_TICKS, 16'd0);
    send_request(16'h0000, 1'b1, 4'd0, idle_span());
    wait_idle();
    set_register(REG_WINDOW_TICKS, 16'd255);
    set_register(REG_PRESENCE_THRESHOLD, 16'd3);
    repeat (3) send_request(16'h00FF, 1'b0, 4'd0, idle_span());
    repeat (255) send_request(MASK_W'($urandom), 1'b1, SEL_W'($urandom_range(0, 15)),
                              idle_span());
    send_request(16'h0000, 1'b1, 4'd8, idle_span());
    for (int ch = 0; ch < CHANNELS_DEF; ch++)
      send_request(16'h0000, 1'b0, SEL_W'(ch), idle_span());
    quick = 1'b0;

    wait_idle();
    @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gppd_pkg.sv
design/gppd_if.sv
design/gated_pulse_presence_detector.sv
design/gppd_checker.sv
dv/gppd_presence_checker.sv
dv/gated_pulse_presence_detector_tb.sv
